FILE: design/hsv2rgb_pkg.sv
`default_nettype none

package hsv2rgb_pkg;

    // Fixed-point format: 16 fraction bits, 1.0 is 2^16.
    localparam int FRAC_BITS = 16;
    localparam int UNIT_W    = FRAC_BITS + 1;
    localparam logic [UNIT_W-1:0] UNIT_ONE = UNIT_W'(1) << FRAC_BITS;

    // Input and output field widths.
    localparam int HUE_W = 16;
    localparam int SV_W  = 18;

    // Reciprocal constants for division by constants.
    // floor(y / 45) = (y * RECIP_45) >> SHIFT_45 for y up to 4096.
    localparam int RECIP_45_W = 13;
    localparam logic [RECIP_45_W-1:0] RECIP_45 = 13'd5826;
    localparam int SHIFT_45 = 18;
    localparam logic [8:0] DEG_360 = 9'd360;

    // floor(z / 15) = (z * RECIP_15) >> SHIFT_15 for z up to 89.
    localparam logic [6:0] RECIP_15 = 7'd69;
    localparam int SHIFT_15 = 10;
    localparam logic [5:0] DEG_60 = 6'd60;

    // floor(k * 2^16 / 60) = (k * RECIP_FRAC) >> SHIFT_FRAC for k up to 59.
    localparam int RECIP_FRAC_W = 21;
    localparam logic [RECIP_FRAC_W-1:0] RECIP_FRAC = 21'd1118482;
    localparam int SHIFT_FRAC = 10;

    // Output selection by hue sector; SEC_5 also covers negative sectors.
    typedef enum logic [2:0] {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } t_sector;

endpackage

`default_nettype wire

FILE: design/hsv_to_rgb_converter.sv
`default_nettype none

// Channel   | Signals                                   | Direction
// ----------+-------------------------------------------+----------
// pixel in  | i_start, o_busy, i_hue, i_saturation,     | input
//           | i_brightness                              |
// color out | o_valid, o_red, o_green, o_blue           | output
//
// A word is accepted at each rising edge with i_start high and o_busy low.
// o_busy is always low and the receiver cannot stall, so one word enters per clock.
// Each result appears on the outputs with o_valid high for one cycle.
// The seven register stages: hue quotient, remainder modulo 360, sector split,
// fraction, two rows of 17x17 products, and the output select.
// Reset is synchronous, active low, and clears only the valid bits.
module hsv_to_rgb_converter (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    output logic                               o_busy,
    input  wire logic signed [hsv2rgb_pkg::HUE_W-1:0] i_hue,
    input  wire logic signed [hsv2rgb_pkg::SV_W-1:0]  i_saturation,
    input  wire logic signed [hsv2rgb_pkg::SV_W-1:0]  i_brightness,
    output logic                               o_valid,
    output logic [hsv2rgb_pkg::UNIT_W-1:0]     o_red,
    output logic [hsv2rgb_pkg::UNIT_W-1:0]     o_green,
    output logic [hsv2rgb_pkg::UNIT_W-1:0]     o_blue
);
    import hsv2rgb_pkg::*;

    localparam int STAGES = 7;

    // Valid bits, one per stage.
    logic [STAGES-1:0] r_vld;

    // Stage 1 registers.
    logic              r1_neg;
    logic [15:0]       r1_mag;
    logic [6:0]        r1_quo;
    logic [UNIT_W-1:0] r1_s, r1_v;
    // Stage 2 registers.
    logic              r2_neg;
    logic [8:0]        r2_rem;
    logic [UNIT_W-1:0] r2_s, r2_v, r2_p;
    // Stage 3 registers.
    t_sector           r3_sel;
    logic [5:0]        r3_idx;
    logic [UNIT_W-1:0] r3_s, r3_v, r3_p;
    // Stage 4 registers.
    t_sector           r4_sel;
    logic [15:0]       r4_f;
    logic [UNIT_W-1:0] r4_s, r4_v, r4_p;
    // Stage 5 registers.
    t_sector           r5_sel;
    logic [UNIT_W-1:0] r5_sf, r5_sg, r5_v, r5_p;
    // Stage 6 registers.
    t_sector           r6_sel;
    logic [UNIT_W-1:0] r6_q, r6_t, r6_v, r6_p;

    // Stage 1 next values.
    logic              n1_neg;
    logic [15:0]       n1_mag;
    logic [25:0]       quo_prod;
    logic [UNIT_W-1:0] n1_s, n1_v;

    // Clamp saturation and value into 0..1, and take the hue magnitude.
    always_comb begin
        if (i_saturation[SV_W-1]) begin
            n1_s = '0;
        end else if (i_saturation > $signed({1'b0, UNIT_ONE})) begin
            n1_s = UNIT_ONE;
        end else begin
            n1_s = i_saturation[UNIT_W-1:0];
        end
        if (i_brightness[SV_W-1]) begin
            n1_v = '0;
        end else if (i_brightness > $signed({1'b0, UNIT_ONE})) begin
            n1_v = UNIT_ONE;
        end else begin
            n1_v = i_brightness[UNIT_W-1:0];
        end
        n1_neg   = i_hue[HUE_W-1];
        n1_mag   = n1_neg ? (~i_hue + 16'd1) : i_hue;
        // |hue| / 360 as (|hue| / 8) / 45.
        quo_prod = n1_mag[15:3] * RECIP_45;
    end

    // Stage 2: remainder modulo 360 and the p term.
    logic [15:0]   quo_360;
    logic [15:0]   rem_full;
    logic [33:0]   p_prod;
    always_comb begin
        quo_360  = 16'(r1_quo) * 16'(DEG_360);
        rem_full = r1_mag - quo_360;
        p_prod   = r1_v * (UNIT_ONE - r1_s);
    end

    // Stage 3: split the remainder into sector and offset inside it.
    // A negative remainder gives a negative sector, which selects like sector 5.
    logic [13:0] sec_prod;
    logic [2:0]  sec_mag;
    logic [8:0]  sec_off;
    logic [5:0]  off_low;
    t_sector     n3_sel;
    logic [5:0]  n3_idx;
    always_comb begin
        sec_prod = r2_rem[8:2] * RECIP_15;
        sec_mag  = sec_prod[12:SHIFT_15];
        sec_off  = r2_rem - (9'(sec_mag) * 9'(DEG_60));
        off_low  = sec_off[5:0];
        if (r2_neg && (r2_rem != '0)) begin
            n3_sel = SEC_5;
            n3_idx = (off_low == '0) ? '0 : (DEG_60 - off_low);
        end else begin
            n3_sel = t_sector'(sec_mag);
            n3_idx = off_low;
        end
    end

    // Stage 4: fraction f = floor(offset * 1.0 / 60).
    logic [26:0] f_prod;
    assign f_prod = r3_idx * RECIP_FRAC;

    // Stage 5: s*f and s*(1-f).
    logic [33:0] sf_prod, sg_prod;
    always_comb begin
        sf_prod = r4_s * {1'b0, r4_f};
        sg_prod = r4_s * (UNIT_ONE - {1'b0, r4_f});
    end

    // Stage 6: q = v(1-sf) and t = v(1-s(1-f)).
    logic [33:0] q_prod, t_prod;
    always_comb begin
        q_prod = r5_v * (UNIT_ONE - r5_sf);
        t_prod = r5_v * (UNIT_ONE - r5_sg);
    end

    // Valid bits travel with the data; nothing ever stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[STAGES-2:0], i_start && !o_busy};
        end
    end

    // Data path registers.
    always_ff @(posedge i_clk) begin
        r1_neg <= n1_neg;
        r1_mag <= n1_mag;
        r1_quo <= quo_prod[SHIFT_45+6:SHIFT_45];
        r1_s   <= n1_s;
        r1_v   <= n1_v;

        r2_neg <= r1_neg;
        r2_rem <= rem_full[8:0];
        r2_s   <= r1_s;
        r2_v   <= r1_v;
        r2_p   <= p_prod[FRAC_BITS+UNIT_W-1:FRAC_BITS];

        r3_sel <= n3_sel;
        r3_idx <= n3_idx;
        r3_s   <= r2_s;
        r3_v   <= r2_v;
        r3_p   <= r2_p;

        r4_sel <= r3_sel;
        r4_f   <= f_prod[SHIFT_FRAC+15:SHIFT_FRAC];
        r4_s   <= r3_s;
        r4_v   <= r3_v;
        r4_p   <= r3_p;

        r5_sel <= r4_sel;
        r5_sf  <= sf_prod[FRAC_BITS+UNIT_W-1:FRAC_BITS];
        r5_sg  <= sg_prod[FRAC_BITS+UNIT_W-1:FRAC_BITS];
        r5_v   <= r4_v;
        r5_p   <= r4_p;

        r6_sel <= r5_sel;
        r6_q   <= q_prod[FRAC_BITS+UNIT_W-1:FRAC_BITS];
        r6_t   <= t_prod[FRAC_BITS+UNIT_W-1:FRAC_BITS];
        r6_v   <= r5_v;
        r6_p   <= r5_p;
    end

    // Output select by sector. With zero saturation p, q and t all equal v,
    // so grey needs no path of its own.
    always_ff @(posedge i_clk) begin
        unique case (r6_sel)
            SEC_0: begin
                o_red <= r6_v; o_green <= r6_t; o_blue <= r6_p;
            end
            SEC_1: begin
                o_red <= r6_q; o_green <= r6_v; o_blue <= r6_p;
            end
            SEC_2: begin
                o_red <= r6_p; o_green <= r6_v; o_blue <= r6_t;
            end
            SEC_3: begin
                o_red <= r6_p; o_green <= r6_q; o_blue <= r6_v;
            end
            SEC_4: begin
                o_red <= r6_t; o_green <= r6_p; o_blue <= r6_v;
            end
            default: begin
                o_red <= r6_v; o_green <= r6_p; o_blue <= r6_q;
            end
        endcase
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_busy  = 1'b0;

endmodule

`default_nettype wire

FILE: verif/tb_hsv_to_rgb_converter.sv
`timescale 1ns / 1ps

module tb_hsv_to_rgb_converter;
    import hsv2rgb_pkg::*;

    localparam int  CLK_HALF    = 6;
    localparam int  RESET_LEN   = 11;
    localparam int  RANDOM_WORDS = 1600;
    localparam int  QUIET_TAIL  = 300;
    localparam int  DRAIN_WAIT  = 16;
    localparam int  CYCLE_LIMIT = 200000;
    localparam longint UNIT     = longint'(1) << FRAC_BITS;

    typedef struct packed {
        logic [UNIT_W-1:0] red;
        logic [UNIT_W-1:0] green;
        logic [UNIT_W-1:0] blue;
    } t_rgb_word;

    // Scoreboard: predicts the color of each accepted pixel and checks results in order.
    class color_scoreboard;
        t_rgb_word expected_q[$];
        int        mismatches;

        function new();
            mismatches = 0;
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH: %s", msg);
            mismatches++;
        endtask

        // Clamp a fixed-point channel to the unit interval.
        function longint clamp_unit(longint x);
            if (x < 0) return 0;
            if (x > UNIT) return UNIT;
            return x;
        endfunction

        // Truncating fixed-point product; both operands are non-negative here.
        function longint fx_product(longint a, longint b);
            return (a * b) >>> FRAC_BITS;
        endfunction

        function t_rgb_word predict_color(logic signed [HUE_W-1:0] hue,
                                          logic signed [SV_W-1:0]  sat,
                                          logic signed [SV_W-1:0]  bri);
            longint    h;
            longint    s;
            longint    v;
            longint    rem;
            longint    sec_num;
            longint    frac;
            longint    p;
            longint    q;
            longint    t;
            t_sector   sec;
            t_rgb_word c;
            h = hue;
            s = clamp_unit(sat);
            v = clamp_unit(bri);
            // Zero saturation gives grey.
            if (s == 0) begin
                c.red   = UNIT_W'(v);
                c.green = UNIT_W'(v);
                c.blue  = UNIT_W'(v);
                return c;
            end
            // Truncating remainder keeps the sign of the hue; the sector is floored.
            rem = h % 360;
            if (rem >= 0) sec_num = rem / 60;
            else sec_num = -((-rem + 59) / 60);
            frac = ((rem - 60 * sec_num) * UNIT) / 60;
            p = fx_product(v, UNIT - s);
            q = fx_product(v, UNIT - fx_product(s, frac));
            t = fx_product(v, UNIT - fx_product(s, UNIT - frac));
            // Negative sectors share the last sector's selection.
            if (sec_num < 0 || sec_num > 5) sec = SEC_5;
            else sec = t_sector'(sec_num[2:0]);
            case (sec)
                SEC_0: begin c.red = UNIT_W'(v); c.green = UNIT_W'(t); c.blue = UNIT_W'(p); end
                SEC_1: begin c.red = UNIT_W'(q); c.green = UNIT_W'(v); c.blue = UNIT_W'(p); end
                SEC_2: begin c.red = UNIT_W'(p); c.green = UNIT_W'(v); c.blue = UNIT_W'(t); end
                SEC_3: begin c.red = UNIT_W'(p); c.green = UNIT_W'(q); c.blue = UNIT_W'(v); end
                SEC_4: begin c.red = UNIT_W'(t); c.green = UNIT_W'(p); c.blue = UNIT_W'(v); end
                default: begin
                    c.red = UNIT_W'(v); c.green = UNIT_W'(p); c.blue = UNIT_W'(q);
                end
            endcase
            return c;
        endfunction

        function void note_pixel(logic signed [HUE_W-1:0] hue,
                                 logic signed [SV_W-1:0]  sat,
                                 logic signed [SV_W-1:0]  bri);
            expected_q.push_back(predict_color(hue, sat, bri));
        endfunction

        task check_color(logic [UNIT_W-1:0] r, logic [UNIT_W-1:0] g,
                         logic [UNIT_W-1:0] b);
            t_rgb_word e;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result r=%0d g=%0d b=%0d", r, g, b));
                return;
            end
            e = expected_q.pop_front();
            if (r !== e.red)
                report_mismatch($sformatf("red got %0d expected %0d", r, e.red));
            if (g !== e.green)
                report_mismatch($sformatf("green got %0d expected %0d", g, e.green));
            if (b !== e.blue)
                report_mismatch($sformatf("blue got %0d expected %0d", b, e.blue));
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_start;
    logic                     o_busy;
    logic signed [HUE_W-1:0]  i_hue;
    logic signed [SV_W-1:0]   i_saturation;
    logic signed [SV_W-1:0]   i_brightness;
    logic                     o_valid;
    logic [UNIT_W-1:0]        o_red;
    logic [UNIT_W-1:0]        o_green;
    logic [UNIT_W-1:0]        o_blue;

    color_scoreboard colors = new();
    int              cycle_count = 0;
    bit              idle_enabled = 1'b1;

    hsv_to_rgb_converter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_valid      (o_valid),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // Watchdog against a hung pipeline.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_hsv_to_rgb_converter: done, errors");
            $finish;
        end
    end

    // Monitor: checks each result word and notes each accepted pixel word.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) colors.check_color(o_red, o_green, o_blue);
            if (i_start && !o_busy) colors.note_pixel(i_hue, i_saturation, i_brightness);
        end
    end

    // Drives one pixel word, with an optional idle burst ahead of it.
    task send_pixel(logic signed [HUE_W-1:0] hue, logic signed [SV_W-1:0] sat,
                    logic signed [SV_W-1:0] bri);
        int gap;
        if (idle_enabled && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start      <= 1'b1;
        i_hue        <= hue;
        i_saturation <= sat;
        i_brightness <= bri;
        do @(posedge i_clk); while (o_busy);
    endtask

    // Random pixel: mostly in-range channels, some near-range hues, some raw noise.
    task send_random_pixel();
        logic signed [HUE_W-1:0] hue;
        logic signed [SV_W-1:0]  sat;
        logic signed [SV_W-1:0]  bri;
        int                      pick;
        hue  = HUE_W'($urandom);
        sat  = SV_W'($urandom_range(0, 65536));
        bri  = SV_W'($urandom_range(0, 65536));
        pick = $urandom_range(0, 9);
        if (pick < 3) hue = HUE_W'($signed($urandom_range(0, 1440)) - 720);
        if (pick == 4) sat = SV_W'($urandom);
        if (pick == 5) bri = SV_W'($urandom);
        if (pick == 6) begin
            sat = SV_W'($urandom);
            bri = SV_W'($urandom);
        end
        if (pick == 7) sat = ($urandom_range(0, 1) == 0) ? SV_W'(0) : SV_W'(UNIT);
        if (pick == 8) bri = ($urandom_range(0, 1) == 0) ? SV_W'(0) : SV_W'(UNIT);
        send_pixel(hue, sat, bri);
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_start      <= 1'b0;
        i_hue        <= '0;
        i_saturation <= '0;
        i_brightness <= '0;
        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: one hue per sector, negative sectors, hue extremes and wraps.
        send_pixel(16'sd30,     18'sd40000,  18'sd60000);
        send_pixel(16'sd90,     18'sd40000,  18'sd60000);
        send_pixel(16'sd150,    18'sd40000,  18'sd60000);
        send_pixel(16'sd210,    18'sd40000,  18'sd60000);
        send_pixel(16'sd270,    18'sd40000,  18'sd60000);
        send_pixel(16'sd330,    18'sd40000,  18'sd60000);
        send_pixel(-16'sd30,    18'sd40000,  18'sd60000);
        send_pixel(-16'sd330,   18'sd40000,  18'sd60000);
        send_pixel(-16'sd359,   18'sd65536,  18'sd65536);
        send_pixel(16'sd359,    18'sd65536,  18'sd65536);
        send_pixel(16'sd360,    18'sd65536,  18'sd65536);
        send_pixel(-16'sd360,   18'sd65536,  18'sd65536);
        send_pixel(-16'sd1,     18'sd12345,  18'sd54321);
        send_pixel(16'sd0,      18'sd65536,  18'sd65536);
        send_pixel(16'sh7fff,   18'sd65535,  18'sd65535);
        send_pixel(-16'sh8000,  18'sd65535,  18'sd65535);
        // Grey, including saturation clamped up from below zero.
        send_pixel(16'sd100,    18'sd0,      18'sd30000);
        send_pixel(16'sd200,    -18'sd5,     18'sd30000);
        send_pixel(16'sd45,     -18'sd131072, 18'sd131071);
        // Channels clamped down from above one and up from below zero.
        send_pixel(16'sd45,     18'sd131071, 18'sd131071);
        send_pixel(16'sd120,    18'sd70000,  -18'sd131072);
        send_pixel(16'sd240,    18'sd1,      -18'sd1);
        send_pixel(16'sd300,    18'sd1,      18'sd65536);
        send_pixel(16'sd60,     18'sd65536,  18'sd0);
        send_pixel(-16'sd60,    18'sd32768,  18'sd65537);

        // Random part; the tail runs back to back.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS - QUIET_TAIL) idle_enabled = 1'b0;
            send_random_pixel();
        end
        i_start <= 1'b0;

        // Drain, then allow a few more cycles for stray results.
        while (colors.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (colors.mismatches == 0) begin
            $display("tb_hsv_to_rgb_converter: done, clean");
        end else begin
            $display("tb_hsv_to_rgb_converter: done, errors");
        end
        $finish;
    end

endmodule
